// File: src/i2c_bitbang_transaction_master_core_defines.svh
// Assertion macros for the I2C transaction master checker.
// Depends on nothing; included by the checker file.
`ifndef I2C_BITBANG_TRANSACTION_MASTER_CORE_DEFINES_SVH
`define I2C_BITBANG_TRANSACTION_MASTER_CORE_DEFINES_SVH
// Assert an implication on every clock edge outside reset.
`define I2CM_ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("i2cm check failed");
`endif

// File: src/i2cm_pkg.sv
// Package for the I2C transaction master: phases, codes, constants.
// Depends on nothing.
package i2cm_pkg;
  localparam int unsigned MaxBytesDef = 256;
  localparam int unsigned MaxAddrBytesDef = 2;
  localparam int unsigned ResetClocksDef = 9;
  localparam logic [6:0] ChipAddrReset = 7'd32;

  typedef enum logic [3:0] {
    PhIdle, PhStart, PhWbit, PhWack, PhWait, PhRbit, PhRack, PhStop, PhRclk
  } phase_e;

  typedef enum logic [1:0] {
    RoleChipW, RoleAddr, RoleData, RoleChipR
  } role_e;

  localparam logic [1:0] ReqCmd  = 2'd0;
  localparam logic [1:0] ReqData = 2'd1;
  localparam logic [1:0] ReqTick = 2'd2;

  localparam logic [1:0] OpWrite = 2'd0;
  localparam logic [1:0] OpRead  = 2'd1;
  localparam logic [1:0] OpReset = 2'd2;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StChipNack = 2'd1;
  localparam logic [1:0] StAddrNack = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  operation;
    logic [15:0] register_address;
    logic [1:0]  address_length;
    logic [8:0]  byte_count;
    logic [7:0]  write_data;
    logic        sda_level;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       need_data;
    logic       read_valid;
    logic [7:0] read_value;
    logic       read_last;
    logic       done_res;
    logic [1:0] status;
    logic [8:0] nack_count;
  } out_item_t;
endpackage

// File: src/i2cm_if.sv
// Valid/ready channel interfaces for the I2C transaction master.
// Depends on i2cm_pkg.
interface i2cm_in_if import i2cm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cm_out_if import i2cm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/i2c_bitbang_transaction_master_core.sv
// I2C bit-bang transaction master: one tick item advances the bus sequence
// by one time slot. One item is accepted per cycle; a tick's result is held
// in a single output register, so input stalls only while that register is
// full and not taken. Depends on i2cm_pkg and i2cm_if.
module i2c_bitbang_transaction_master_core import i2cm_pkg::*; #(
  parameter int unsigned ResetClocks  = ResetClocksDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  i2cm_in_if.sink    in_ch,
  i2cm_out_if.source out_ch
);
  localparam logic [8:0] MaxBytesW = 9'(MaxBytesDef);
  localparam logic [1:0] MaxAlenW  = 2'(MaxAddrBytesDef);
  localparam logic [5:0] RstClkW   = 6'(ResetClocks);

  logic [6:0]  chip_q, chip_latch_q, chip_latch_d;
  phase_e      ph_q, ph_d;
  role_e       role_q, role_d;
  logic [5:0]  bitc_q, bitc_d;
  logic [7:0]  sh_q, sh_d;
  logic [8:0]  left_q, left_d;
  logic [1:0]  aleft_q, aleft_d;
  logic [15:0] alat_q, alat_d;
  logic [1:0]  op_q, op_d;
  logic [8:0]  fail_q, fail_d;
  logic        scl_q, scl_d, sda_q, sda_d;
  logic [2:0]  st_q, st_d;
  logic        nack_q, nack_d;
  logic [1:0]  est_q, est_d;
  logic        rst_after_q, rst_after_d;
  logic        ov_q;
  out_item_t   od_q, res;
  logic        acc, tick;
  in_item_t    it;
  logic [1:0]  alen_s;
  logic [8:0]  cnt_s;
  logic [7:0]  abyte;
  logic        last;

  assign in_ch.ready  = !ov_q || out_ch.ready;
  assign acc          = in_ch.valid && in_ch.ready;
  assign it           = in_ch.data;
  assign tick         = acc && it.req_type == ReqTick;
  assign out_ch.valid = ov_q;
  assign out_ch.data  = od_q;
  assign last         = left_q <= 9'd1;

  always_comb begin
    unique case (aleft_q)
      2'd1:    abyte = alat_q[7:0];
      2'd2:    abyte = alat_q[15:8];
      default: abyte = 8'd0;
    endcase
  end

  always_comb begin
    ph_d = ph_q; role_d = role_q; bitc_d = bitc_q; sh_d = sh_q;
    left_d = left_q; aleft_d = aleft_q; alat_d = alat_q; op_d = op_q;
    fail_d = fail_q; scl_d = scl_q; sda_d = sda_q; st_d = st_q;
    nack_d = nack_q; est_d = est_q; rst_after_d = rst_after_q;
    chip_latch_d = chip_latch_q;
    res = '0;
    alen_s = (it.address_length > MaxAlenW) ? MaxAlenW : it.address_length;
    cnt_s  = (it.byte_count > MaxBytesW) ? MaxBytesW : it.byte_count;
    if (acc && it.req_type == ReqCmd && ph_q == PhIdle && it.operation <= OpReset) begin
      op_d = it.operation; chip_latch_d = chip_q; fail_d = '0; est_d = StOk;
      rst_after_d = 1'b0; nack_d = 1'b0; st_d = '0; bitc_d = '0;
      alat_d = it.register_address;
      if (it.operation == OpReset) begin
        left_d = '0; aleft_d = '0; ph_d = PhRclk;
      end else begin
        left_d = cnt_s; aleft_d = alen_s; sh_d = {chip_q, 1'b0};
        if (it.operation == OpRead && alen_s == 2'd0) begin
          role_d = RoleChipR; sh_d[0] = 1'b1;
        end else begin
          role_d = RoleChipW;
        end
        ph_d = PhStart;
      end
    end else if (acc && it.req_type == ReqData && ph_q == PhWait) begin
      sh_d = it.write_data; bitc_d = '0; st_d = '0; ph_d = PhWbit;
    end else if (tick) begin
      res.busy_res = ph_q != PhIdle;
      st_d = st_q + 3'd1;
      unique case (ph_q)
        PhStart: begin
          if (st_q == 3'd1) sda_d = 1'b1;
          if (st_q == 3'd2) scl_d = 1'b1;
          if (st_q >= 3'd3) begin
            sda_d = 1'b0; bitc_d = '0; st_d = '0; ph_d = PhWbit;
          end
        end
        PhWbit: begin
          if (st_q == 3'd0) scl_d = 1'b0;
          if (st_q == 3'd1) sda_d = sh_q[7];
          if (st_q == 3'd2) scl_d = 1'b1;
          if (st_q >= 3'd3) begin
            sh_d = {sh_q[6:0], 1'b0}; bitc_d = bitc_q + 6'd1; st_d = '0;
            if (bitc_q + 6'd1 >= 6'd8) ph_d = PhWack;
          end
        end
        PhWack: begin
          if (st_q == 3'd0) scl_d = 1'b0;
          if (st_q == 3'd1) sda_d = 1'b1;
          if (st_q == 3'd2) scl_d = 1'b1;
          if (st_q == 3'd3) nack_d = it.sda_level;
          if (st_q >= 3'd4) begin
            scl_d = 1'b0; st_d = '0;
            unique case (role_q)
              RoleChipW: begin
                if (nack_q) begin
                  est_d = StChipNack; ph_d = PhStop;
                end else if (aleft_q != 2'd0) begin
                  role_d = RoleAddr; sh_d = abyte; bitc_d = '0; ph_d = PhWbit;
                end else begin
                  role_d = RoleData;
                  ph_d = (left_q != '0) ? PhWait : PhStop;
                end
              end
              RoleAddr: begin
                if (nack_q) begin
                  est_d = StAddrNack; ph_d = PhStop;
                end else begin
                  aleft_d = aleft_q - 2'd1;
                  if (aleft_q != 2'd1) begin
                    sh_d = alat_q[7:0]; bitc_d = '0; ph_d = PhWbit;
                  end else if (op_q == OpRead) begin
                    rst_after_d = 1'b1; ph_d = PhStop;
                  end else begin
                    role_d = RoleData;
                    ph_d = (left_q != '0) ? PhWait : PhStop;
                  end
                end
              end
              RoleData: begin
                if (nack_q && fail_q != 9'd511) fail_d = fail_q + 9'd1;
                left_d = (left_q != '0) ? left_q - 9'd1 : left_q;
                ph_d = (left_q > 9'd1) ? PhWait : PhStop;
              end
              default: begin
                if (nack_q) begin
                  est_d = StChipNack; ph_d = PhStop;
                end else if (left_q != '0) begin
                  bitc_d = '0; sh_d = '0; ph_d = PhRbit;
                end else begin
                  ph_d = PhStop;
                end
              end
            endcase
          end
        end
        PhWait: begin
          res.need_data = 1'b1; st_d = '0;
        end
        PhRbit: begin
          if (st_q == 3'd0) begin
            scl_d = 1'b0;
            if (bitc_q == '0) sda_d = 1'b1;
          end
          if (st_q == 3'd1) begin
            scl_d = 1'b1; sh_d = {sh_q[6:0], it.sda_level};
          end
          if (st_q >= 3'd2) begin
            bitc_d = bitc_q + 6'd1; st_d = '0;
            if (bitc_q + 6'd1 >= 6'd8) ph_d = PhRack;
          end
        end
        PhRack: begin
          if (st_q == 3'd0) scl_d = 1'b0;
          if (st_q == 3'd1) sda_d = last;
          if (st_q == 3'd2) scl_d = 1'b1;
          if (st_q >= 3'd4) begin
            scl_d = 1'b0; res.read_valid = 1'b1; res.read_value = sh_q;
            res.read_last = last; st_d = '0;
            left_d = (left_q != '0) ? left_q - 9'd1 : left_q;
            if (left_q > 9'd1) begin
              bitc_d = '0; sh_d = '0; ph_d = PhRbit;
            end else begin
              ph_d = PhStop;
            end
          end
        end
        PhStop: begin
          if (st_q == 3'd0) scl_d = 1'b0;
          if (st_q == 3'd1) sda_d = 1'b0;
          if (st_q == 3'd2) scl_d = 1'b1;
          if (st_q >= 3'd3) begin
            sda_d = 1'b1; st_d = '0;
            if (rst_after_q) begin
              rst_after_d = 1'b0; role_d = RoleChipR;
              sh_d = {chip_latch_q, 1'b1}; ph_d = PhStart;
            end else begin
              res.done_res = 1'b1; res.status = est_q; res.nack_count = fail_q;
              ph_d = PhIdle;
            end
          end
        end
        PhRclk: begin
          if (st_q == 3'd0) begin
            scl_d = 1'b0; sda_d = 1'b1;
          end
          if (st_q == 3'd2) scl_d = 1'b1;
          if (st_q >= 3'd3) begin
            bitc_d = bitc_q + 6'd1; st_d = '0;
            if (bitc_q + 6'd1 >= RstClkW) begin
              est_d = StOk; rst_after_d = 1'b0; ph_d = PhStop;
            end
          end
        end
        default: begin
          ph_d = PhIdle; st_d = '0;
        end
      endcase
      res.scl_level = scl_d;
      res.sda_release = sda_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chip_q <= ChipAddrReset; ph_q <= PhIdle; role_q <= RoleChipW;
      bitc_q <= '0; sh_q <= '0; left_q <= '0; aleft_q <= '0; alat_q <= '0;
      op_q <= '0; fail_q <= '0; scl_q <= 1'b1; sda_q <= 1'b1; st_q <= '0;
      nack_q <= 1'b0; est_q <= StOk; rst_after_q <= 1'b0;
      chip_latch_q <= '0; ov_q <= 1'b0;
    end else begin
      if (cfg_we_i) chip_q <= cfg_wdata_i;
      ph_q <= ph_d; role_q <= role_d; bitc_q <= bitc_d; sh_q <= sh_d;
      left_q <= left_d; aleft_q <= aleft_d; alat_q <= alat_d; op_q <= op_d;
      fail_q <= fail_d; scl_q <= scl_d; sda_q <= sda_d; st_q <= st_d;
      nack_q <= nack_d; est_q <= est_d; rst_after_q <= rst_after_d;
      chip_latch_q <= chip_latch_d;
      if (tick) ov_q <= 1'b1;
      else if (out_ch.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) od_q <= res;
  end
endmodule

// File: src/i2cm_checker.sv
// Port-level checks for the I2C transaction master, bound to the top level.
// Depends on i2cm_pkg and the defines header.
`include "i2c_bitbang_transaction_master_core_defines.svh"
module i2cm_port_sva import i2cm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid,
  input logic      out_ready,
  input logic      in_ready,
  input out_item_t out_data
);
  `I2CM_ASSERT_IMPL(a_hold, clk_i, rst_ni,
    out_valid && !out_ready |=> out_valid && $stable(out_data))
  `I2CM_ASSERT_IMPL(a_rdy, clk_i, rst_ni, !out_valid |-> in_ready)
  `I2CM_ASSERT_IMPL(a_done, clk_i, rst_ni,
    out_valid && out_data.done_res |->
      out_data.busy_res && out_data.scl_level && out_data.sda_release)
  `I2CM_ASSERT_IMPL(a_rv, clk_i, rst_ni,
    out_valid && !out_data.read_valid |-> out_data.read_value == 8'd0)
endmodule

bind i2c_bitbang_transaction_master_core i2cm_port_sva u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .in_ready(in_ch.ready), .out_data(out_ch.data)
);

// File: dv/i2cm_checker.sv
`timescale 1ns / 1ps
// Checker for the I2C transaction master: watches both channels and the config
// port, predicts each tick result and compares it. Depends on i2cm_pkg, i2cm_if.
module i2cm_checker import i2cm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  i2cm_in_if         in_mon,
  i2cm_out_if        out_mon,
  output int         fail_count_o,
  output int         ticks_pending_o,
  output logic       cmd_active_o
);
  phase_e      ph;
  role_e       role;
  logic [3:0]  bitc;
  logic [7:0]  shreg;
  logic [8:0]  bytes_left;
  logic [1:0]  addr_left;
  logic [15:0] addr_lat;
  logic [1:0]  cur_op;
  logic [8:0]  data_nacks;
  logic        scl_q, sda_q, nack, restart;
  logic [2:0]  slot;
  logic [1:0]  end_st;
  logic [6:0]  chip_cfg, chip_lat;
  out_item_t   tick_q[$];
  int          fails;

  assign fail_count_o    = fails;
  assign ticks_pending_o = tick_q.size();
  assign cmd_active_o    = (ph != PhIdle);

  task automatic load_wbit(input logic [7:0] v);
    shreg = v;
    bitc  = '0;
    slot  = '0;
    ph    = PhWbit;
  endtask

  task automatic load_addr_byte();
    load_wbit((addr_left == 2'd2) ? addr_lat[15:8] : addr_lat[7:0]);
  endtask

  task automatic go_stop(input logic [1:0] code, input logic rs);
    end_st  = code;
    restart = rs;
    slot    = '0;
    ph      = PhStop;
  endtask

  task automatic data_phase();
    if (bytes_left > 0) begin
      slot = '0;
      ph   = PhWait;
    end else begin
      go_stop(StOk, 1'b0);
    end
  endtask

  task automatic read_phase();
    if (bytes_left > 0) begin
      bitc  = '0;
      shreg = '0;
      slot  = '0;
      ph    = PhRbit;
    end else begin
      go_stop(StOk, 1'b0);
    end
  endtask

  task automatic after_wack();
    case (role)
      RoleChipW: begin
        if (nack) go_stop(StChipNack, 1'b0);
        else if (addr_left > 0) begin
          role = RoleAddr;
          load_addr_byte();
        end else begin
          role = RoleData;
          data_phase();
        end
      end
      RoleAddr: begin
        if (nack) go_stop(StAddrNack, 1'b0);
        else begin
          addr_left--;
          if (addr_left > 0) load_addr_byte();
          else if (cur_op == OpRead) go_stop(StOk, 1'b1);
          else begin
            role = RoleData;
            data_phase();
          end
        end
      end
      RoleData: begin
        if (nack && data_nacks != 9'd511) data_nacks++;
        if (bytes_left > 0) bytes_left--;
        data_phase();
      end
      default: begin
        if (nack) go_stop(StChipNack, 1'b0);
        else read_phase();
      end
    endcase
  endtask

  task automatic issue(input in_item_t d);
    logic [8:0] cnt;
    logic [1:0] alen;
    cnt  = (d.byte_count > 9'd256) ? 9'd256 : d.byte_count;
    alen = (d.address_length > 2'd2) ? 2'd2 : d.address_length;
    if (d.operation == OpWrite || d.operation == OpRead || d.operation == OpReset) begin
      cur_op     = d.operation;
      chip_lat   = chip_cfg;
      data_nacks = '0;
      end_st     = StOk;
      restart    = 1'b0;
      nack       = 1'b0;
      slot       = '0;
      bitc       = '0;
      addr_lat   = d.register_address;
      if (d.operation == OpReset) begin
        bytes_left = '0;
        addr_left  = '0;
        ph         = PhRclk;
      end else begin
        bytes_left = cnt;
        addr_left  = alen;
        shreg      = {chip_lat, 1'b0};
        if (d.operation == OpRead && alen == 2'd0) begin
          role     = RoleChipR;
          shreg[0] = 1'b1;
        end else begin
          role = RoleChipW;
        end
        ph = PhStart;
      end
    end
  endtask

  task automatic tick(input logic sda_in, output out_item_t r);
    logic [2:0] t;
    logic       last;
    t = slot;
    r = '0;
    r.busy_res = (ph != PhIdle);
    slot = t + 3'd1;
    case (ph)
      PhStart: begin
        if (t == 1) sda_q = 1'b1;
        if (t == 2) scl_q = 1'b1;
        if (t >= 3) begin
          sda_q = 1'b0;
          load_wbit(shreg);
        end
      end
      PhWbit: begin
        if (t == 0) scl_q = 1'b0;
        if (t == 1) sda_q = shreg[7];
        if (t == 2) scl_q = 1'b1;
        if (t >= 3) begin
          shreg = shreg << 1;
          bitc++;
          slot = '0;
          if (bitc >= 8) ph = PhWack;
        end
      end
      PhWack: begin
        if (t == 0) scl_q = 1'b0;
        if (t == 1) sda_q = 1'b1;
        if (t == 2) scl_q = 1'b1;
        if (t == 3) nack = sda_in;
        if (t >= 4) begin
          scl_q = 1'b0;
          slot  = '0;
          after_wack();
        end
      end
      PhWait: begin
        r.need_data = 1'b1;
        slot = '0;
      end
      PhRbit: begin
        if (t == 0) begin
          scl_q = 1'b0;
          if (bitc == 0) sda_q = 1'b1;
        end
        if (t == 1) begin
          scl_q = 1'b1;
          shreg = {shreg[6:0], sda_in};
        end
        if (t >= 2) begin
          bitc++;
          slot = '0;
          if (bitc >= 8) ph = PhRack;
        end
      end
      PhRack: begin
        last = (bytes_left <= 1);
        if (t == 0) scl_q = 1'b0;
        if (t == 1) sda_q = last;
        if (t == 2) scl_q = 1'b1;
        if (t >= 4) begin
          scl_q        = 1'b0;
          r.read_valid = 1'b1;
          r.read_value = shreg;
          r.read_last  = last;
          if (bytes_left > 0) bytes_left--;
          read_phase();
        end
      end
      PhStop: begin
        if (t == 0) scl_q = 1'b0;
        if (t == 1) sda_q = 1'b0;
        if (t == 2) scl_q = 1'b1;
        if (t >= 3) begin
          sda_q = 1'b1;
          slot  = '0;
          if (restart) begin
            restart = 1'b0;
            role    = RoleChipR;
            shreg   = {chip_lat, 1'b1};
            ph      = PhStart;
          end else begin
            r.done_res   = 1'b1;
            r.status     = end_st;
            r.nack_count = data_nacks;
            ph           = PhIdle;
          end
        end
      end
      PhRclk: begin
        if (t == 0) begin
          scl_q = 1'b0;
          sda_q = 1'b1;
        end
        if (t == 2) scl_q = 1'b1;
        if (t >= 3) begin
          bitc++;
          slot = '0;
          if (bitc >= ResetClocksDef) go_stop(StOk, 1'b0);
        end
      end
      default: begin
        ph   = PhIdle;
        slot = '0;
      end
    endcase
    r.scl_level   = scl_q;
    r.sda_release = sda_q;
  endtask

  task automatic check_field(input string name, input int e, input int a);
    if (e != a) begin
      fails++;
      if (fails <= 10)
        $display("%0t mismatch %s: expected %0d, got %0d", $realtime, name, e, a);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e, r;
    in_item_t  d;
    if (!rst_ni) begin
      ph = PhIdle; role = RoleChipW; bitc = '0; shreg = '0; bytes_left = '0;
      addr_left = '0; addr_lat = '0; cur_op = '0; data_nacks = '0;
      scl_q = 1'b1; sda_q = 1'b1; nack = 1'b0; restart = 1'b0; slot = '0;
      end_st = '0; chip_cfg = ChipAddrReset; chip_lat = '0;
      tick_q.delete();
      fails = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        r = out_mon.data;
        if (tick_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("%0t unexpected result transfer", $realtime);
        end else begin
          e = tick_q.pop_front();
          check_field("scl_level", e.scl_level, r.scl_level);
          check_field("sda_release", e.sda_release, r.sda_release);
          check_field("busy_res", e.busy_res, r.busy_res);
          check_field("need_data", e.need_data, r.need_data);
          check_field("read_valid", e.read_valid, r.read_valid);
          check_field("read_value", e.read_value, r.read_value);
          check_field("read_last", e.read_last, r.read_last);
          check_field("done_res", e.done_res, r.done_res);
          check_field("status", e.status, r.status);
          check_field("nack_count", e.nack_count, r.nack_count);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        d = in_mon.data;
        case (d.req_type)
          ReqCmd:  if (ph == PhIdle) issue(d);
          ReqData: if (ph == PhWait) load_wbit(d.write_data);
          ReqTick: begin
            tick(d.sda_level, e);
            tick_q.push_back(e);
          end
          default: ;
        endcase
      end
      if (cfg_we_i) chip_cfg = cfg_wdata_i;
    end
  end
endmodule

// File: dv/tb_i2c_bitbang_transaction_master_core.sv
`timescale 1ns / 1ps
// Top of the I2C transaction master testbench: clock, reset, commands, ticks
// and config writes under several idle/stall mixes. Depends on i2cm_pkg,
// i2cm_if, the core and i2cm_checker.
module tb_i2c_bitbang_transaction_master_core;
  import i2cm_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;
  int         fail_count, ticks_pending;
  logic       cmd_active;
  logic       in_taken = 1'b0;
  int         idle_pct = 0, stall_pct = 0, nack_pct = 3;
  int         item_count = 0;
  logic       hold_req = 1'b0;
  longint     cycles = 0;

  i2cm_in_if  in_ch ();
  i2cm_out_if out_ch ();

  i2c_bitbang_transaction_master_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  i2cm_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .fail_count_o    (fail_count),
    .ticks_pending_o (ticks_pending),
    .cmd_active_o    (cmd_active)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    in_taken <= in_ch.valid && in_ch.ready;
    cycles   <= cycles + 1;
    if (cycles > 2000000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off when asked.
  initial begin
    int   hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic put(input in_item_t d);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= d;
    do @(negedge clk); while (!in_taken);
    item_count++;
  endtask

  function automatic in_item_t rand_item(input logic [1:0] req);
    in_item_t d;
    d.req_type         = req;
    d.operation        = 2'($urandom);
    d.register_address = 16'($urandom);
    d.address_length   = 2'($urandom);
    d.byte_count       = 9'($urandom);
    d.write_data       = 8'($urandom);
    d.sda_level        = ($urandom_range(99) < nack_pct);
    return d;
  endfunction

  task automatic run_cmd(input logic [1:0] op, input logic [15:0] ra,
                         input logic [1:0] alen, input logic [8:0] cnt);
    in_item_t d;
    d = rand_item(ReqCmd);
    d.operation        = op;
    d.register_address = ra;
    d.address_length   = alen;
    d.byte_count       = cnt;
    put(d);
    while (cmd_active) begin
      case ($urandom_range(99)) inside
        [0:24]:  put(rand_item(ReqData));
        [25:26]: put(rand_item(ReqCmd));
        [27:28]: put(rand_item(2'd3));
        default: put(rand_item(ReqTick));
      endcase
    end
    repeat ($urandom_range(2)) put(rand_item(ReqTick));
  endtask

  task automatic random_cmds(input int n);
    logic [1:0] op;
    logic [8:0] cnt;
    repeat (n) begin
      case ($urandom_range(99)) inside
        [0:44]:  op = OpWrite;
        [45:84]: op = OpRead;
        [85:94]: op = OpReset;
        default: op = 2'd3;
      endcase
      cnt = 9'($urandom_range(2));
      nack_pct = ($urandom_range(99) < 70) ? 2 : 40;
      run_cmd(op, 16'($urandom), 2'($urandom), cnt);
    end
  endtask

  task automatic write_chip(input logic [6:0] v);
    in_ch.valid <= 1'b0;
    wait (ticks_pending == 0);
    repeat (8) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    nack_pct = 0;
    put(rand_item(ReqData));
    put(rand_item(2'd3));
    put(rand_item(ReqTick));
    run_cmd(OpWrite, 16'hA5C3, 2'd3, 9'd1);
    run_cmd(OpRead, 16'h1234, 2'd0, 9'd1);
    run_cmd(OpReset, 16'h0000, 2'd0, 9'd0);
    run_cmd(2'd3, 16'h0000, 2'd0, 9'd1);
    nack_pct = 100;
    run_cmd(OpWrite, 16'h00FF, 2'd1, 9'd3);

    write_chip(7'd127);
    idle_pct = 77; stall_pct = 0;
    do random_cmds(1); while (item_count < 500);
    write_chip(7'($urandom));
    idle_pct = 0; stall_pct = 77;
    do random_cmds(1); while (item_count < 580);
    write_chip(ChipAddrReset);
    idle_pct = 24; stall_pct = 24;
    do random_cmds(1); while (item_count < 660);
    idle_pct = 0; stall_pct = 10;
    hold_req = 1'b1;
    do random_cmds(1); while (item_count < 740);
    in_ch.valid <= 1'b0;

    wait (ticks_pending == 0);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && ticks_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
